// ----- hdl/imhdk_pkg.sv -----
// Shared types, constants and codes for the indexed min-heap block.
package imhdk_pkg;

  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_KEY_WIDTH = 31;
  localparam int NUM_VERTICES  = 1024;
  localparam int VERT_W        = 10;

  localparam logic [1:0] MODE_INSERT   = 2'd0;
  localparam logic [1:0] MODE_EXTRACT  = 2'd1;
  localparam logic [1:0] MODE_DECREASE = 2'd2;
  localparam logic [1:0] MODE_QUERY    = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  vertex;
    logic [30:0] distance;
  } req_t;

  typedef struct packed {
    logic [9:0]  out_vertex;
    logic [30:0] out_distance;
    logic        got_entry;
    logic        in_heap;
    logic        heap_empty;
    logic [10:0] entry_count;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ----- hdl/imhdk_heap_mem.sv -----
// Heap slot memory: two registered read ports and one write port.
module imhdk_heap_mem #(
  parameter int DEPTH = imhdk_pkg::DEF_CAPACITY,
  parameter int EW    = imhdk_pkg::VERT_W + imhdk_pkg::DEF_KEY_WIDTH
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [EW-1:0]            rdata0,
  output logic [EW-1:0]            rdata1,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [EW-1:0]            wdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- hdl/imhdk_pos_mem.sv -----
// Position table memory: one registered read port and one write port.
module imhdk_pos_mem #(
  parameter int PW = $clog2(imhdk_pkg::DEF_CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic [imhdk_pkg::VERT_W-1:0]   raddr,
  output logic [PW-1:0]                  rdata,
  input  logic                           we,
  input  logic [imhdk_pkg::VERT_W-1:0]   waddr,
  input  logic [PW-1:0]                  wdata
);

  logic [PW-1:0] mem [imhdk_pkg::NUM_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/imhdk_ctrl.sv -----
// Operation sequencer: sift-up and sift-down over the heap and position memories.
module imhdk_ctrl #(
  parameter int CAPACITY  = imhdk_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = imhdk_pkg::DEF_KEY_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  imhdk_pkg::req_t req,
  output logic            req_stall,
  output logic            res_valid,
  output imhdk_pkg::rsp_t res,
  input  logic            res_free
);

  localparam int VW = imhdk_pkg::VERT_W;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = VW + KEY_WIDTH;
  localparam int XW = IW + 2;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_UP_RD    = 4'd3;
  localparam logic [3:0] S_UP_CMP   = 4'd4;
  localparam logic [3:0] S_DN_RD    = 4'd5;
  localparam logic [3:0] S_DN_CMP   = 4'd6;
  localparam logic [3:0] S_WB       = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;
  localparam logic [3:0] S_RES      = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]           state, state_next;
  logic [VW-1:0]        clr, clr_next;
  logic [CW-1:0]        count, count_next;
  logic [1:0]           mode_q, mode_next;
  logic [VW-1:0]        v, v_next;
  logic [KEY_WIDTH-1:0] key_q, key_next;
  logic [IW-1:0]        i, i_next;
  logic [VW-1:0]        cur_v, cur_v_next;
  logic [KEY_WIDTH-1:0] cur_k, cur_k_next;
  logic [1:0]           status, status_next;
  logic [VW-1:0]        ov, ov_next;
  logic [KEY_WIDTH-1:0] od, od_next;
  logic                 got, got_next;
  logic                 inh, inh_next;

  logic [IW-1:0] h_raddr0, h_raddr1, h_waddr;
  logic [EW-1:0] h_rdata0, h_rdata1, h_wdata;
  logic          h_we;
  logic [VW-1:0] p_raddr, p_waddr;
  logic [CW-1:0] p_rdata, p_wdata;
  logic          p_we;

  logic [XW-1:0]        l_idx, r_idx, cnt_x;
  logic                 l_ok, r_ok, sel_l, sel_r, held;
  logic [KEY_WIDTH-1:0] k0, k1, min_k;
  logic [IW-1:0]        parent, last;

  imhdk_heap_mem #(.DEPTH(CAPACITY), .EW(EW)) u_heap (
    .clk(clk), .raddr0(h_raddr0), .raddr1(h_raddr1),
    .rdata0(h_rdata0), .rdata1(h_rdata1),
    .we(h_we), .waddr(h_waddr), .wdata(h_wdata)
  );

  imhdk_pos_mem #(.PW(CW)) u_pos (
    .clk(clk), .raddr(p_raddr), .rdata(p_rdata),
    .we(p_we), .waddr(p_waddr), .wdata(p_wdata)
  );

  assign cnt_x  = XW'(count);
  assign l_idx  = {1'b0, i, 1'b1};
  assign r_idx  = l_idx + XW'(1);
  assign l_ok   = l_idx < cnt_x;
  assign r_ok   = r_idx < cnt_x;
  assign parent = IW'((i - IW'(1)) >> 1);
  assign last   = IW'(count - CW'(1));
  assign k0     = h_rdata0[KEY_WIDTH-1:0];
  assign k1     = h_rdata1[KEY_WIDTH-1:0];
  assign sel_l  = l_ok && (k0 < cur_k);
  assign min_k  = sel_l ? k0 : cur_k;
  assign sel_r  = r_ok && (k1 < min_k);
  assign held   = p_rdata < count;

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.out_vertex   = ov;
    res.out_distance = 31'(od);
    res.got_entry    = got;
    res.in_heap      = inh;
    res.heap_empty   = (count == '0);
    res.entry_count  = 11'(count);
    res.status       = status;
  end

  always_comb begin
    state_next  = state;
    clr_next    = clr;
    count_next  = count;
    mode_next   = mode_q;
    v_next      = v;
    key_next    = key_q;
    i_next      = i;
    cur_v_next  = cur_v;
    cur_k_next  = cur_k;
    status_next = status;
    ov_next     = ov;
    od_next     = od;
    got_next    = got;
    inh_next    = inh;
    h_raddr0    = l_idx[IW-1:0];
    h_raddr1    = r_idx[IW-1:0];
    h_we        = 1'b0;
    h_waddr     = i;
    h_wdata     = h_rdata0;
    p_raddr     = v;
    p_we        = 1'b0;
    p_waddr     = h_rdata0[EW-1:KEY_WIDTH];
    p_wdata     = CW'(i);
    unique case (state)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr;
        p_wdata = CW'(CAPACITY);
        clr_next = clr + VW'(1);
        if (clr == VW'(imhdk_pkg::NUM_VERTICES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // Root and last slot are fetched up front for an extract.
        h_raddr0 = '0;
        h_raddr1 = last;
        p_raddr  = req.vertex;
        if (req_valid) begin
          mode_next   = req.mode;
          v_next      = req.vertex;
          key_next    = KEY_WIDTH'(req.distance);
          status_next = imhdk_pkg::STATUS_OK;
          ov_next     = '0;
          od_next     = '0;
          got_next    = 1'b0;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cur_v_next = v;
        cur_k_next = key_q;
        state_next = S_FIN;
        unique case (mode_q)
          imhdk_pkg::MODE_INSERT: begin
            if (held) begin
              i_next     = p_rdata[IW-1:0];
              state_next = S_UP_RD;
            end else if (count >= CW'(CAPACITY)) begin
              status_next = imhdk_pkg::STATUS_FULL;
            end else begin
              i_next     = count[IW-1:0];
              count_next = count + CW'(1);
              state_next = S_UP_RD;
            end
          end
          imhdk_pkg::MODE_EXTRACT: begin
            if (count == '0) begin
              status_next = imhdk_pkg::STATUS_EMPTY;
            end else begin
              ov_next    = h_rdata0[EW-1:KEY_WIDTH];
              od_next    = k0;
              got_next   = 1'b1;
              count_next = count - CW'(1);
              p_we       = 1'b1;
              p_waddr    = h_rdata0[EW-1:KEY_WIDTH];
              p_wdata    = CW'(CAPACITY);
              if (count != CW'(1)) begin
                cur_v_next = h_rdata1[EW-1:KEY_WIDTH];
                cur_k_next = k1;
                i_next     = '0;
                state_next = S_DN_RD;
              end
            end
          end
          imhdk_pkg::MODE_DECREASE: begin
            if (held) begin
              i_next     = p_rdata[IW-1:0];
              state_next = S_UP_RD;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_UP_RD: begin
        h_raddr0 = parent;
        if (i == '0) begin
          state_next = S_DN_RD;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // The parent drops into the hole; the moving entry is written at the end.
        if (cur_k < k0) begin
          h_we       = 1'b1;
          p_we       = 1'b1;
          i_next     = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (l_ok) begin
          state_next = S_DN_CMP;
        end else begin
          state_next = S_WB;
        end
      end
      S_DN_CMP: begin
        if (sel_r) begin
          h_we       = 1'b1;
          h_wdata    = h_rdata1;
          p_we       = 1'b1;
          p_waddr    = h_rdata1[EW-1:KEY_WIDTH];
          i_next     = r_idx[IW-1:0];
          state_next = S_DN_RD;
        end else if (sel_l) begin
          h_we       = 1'b1;
          p_we       = 1'b1;
          i_next     = l_idx[IW-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        h_we       = 1'b1;
        h_wdata    = {cur_v, cur_k};
        p_we       = 1'b1;
        p_waddr    = cur_v;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_RES;
      end
      S_RES: begin
        inh_next   = held;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      count <= count_next;
    end
    mode_q <= mode_next;
    v      <= v_next;
    key_q  <= key_next;
    i      <= i_next;
    cur_v  <= cur_v_next;
    cur_k  <= cur_k_next;
    status <= status_next;
    ov     <= ov_next;
    od     <= od_next;
    got    <= got_next;
    inh    <= inh_next;
  end

endmodule

// ----- hdl/indexed_min_heap_decrease_key.sv -----
// Top level of the indexed min-heap with decrease-key and its result register.
//
// Requests arrive on req/req_valid/req_stall and each yields exactly one result
// beat on rsp/rsp_valid/rsp_stall. A beat moves when valid is high and stall low.
// Modes: insert, extract minimum, decrease key and membership query.
// One request is worked on at a time. A request that needs no sift passes
// through the dispatch, finish and result states before its result is offered.
// A request that sifts an entry also runs the sift states; each heap level the
// entry moves is one read of the heap memory followed by one compare and
// write-back, and the entry is written to its final slot at the end. The next
// request is accepted only after the result is loaded and the sequencer is idle.
// A finished result sits in the output register, and the next request is
// accepted and worked on while it waits; a stalled receiver only holds the
// sequencer once a second result is ready.
// After reset every position table entry is swept to "absent", during which
// req_stall is high. The heap slots themselves are not cleared.
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY  = imhdk_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = imhdk_pkg::DEF_KEY_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  imhdk_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output imhdk_pkg::rsp_t rsp
);

  logic            res_valid;
  logic            res_free;
  imhdk_pkg::rsp_t res;

  assign res_free = !rsp_valid || !rsp_stall;

  imhdk_ctrl #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req(req), .req_stall(req_stall),
    .res_valid(res_valid), .res(res), .res_free(res_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && res_free) begin
      rsp <= res;
    end
  end

endmodule
